// File: hdl/sctb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctb_pkg: shared types, constants and tables
// Scancode values, command and result types, the set-1 key maps and the
// helpers that expand one command into its result transactions.
// ----------------------------------------------------------------------------
package sctb_pkg;

    // Scancode constants
    localparam logic [7:0] SC_PREFIX_EXT = 8'hE0;
    localparam int         RELEASE_BIT   = 7;
    localparam logic [6:0] KEY_CTRL      = 7'h1D;
    localparam logic [6:0] KEY_ALT       = 7'h38;
    localparam logic [6:0] KEY_CAPS      = 7'h3A;
    localparam logic [6:0] KEY_LSHIFT    = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT    = 7'h36;
    localparam logic [6:0] KEY_C         = 7'h2E;
    localparam logic [6:0] KEY_F1        = 7'h3B;
    localparam logic [6:0] KEY_F5        = 7'h3F;
    localparam logic [6:0] KEY_F6        = 7'h40;
    localparam logic [6:0] KEY_F10       = 7'h44;
    localparam logic [6:0] KEY_F11       = 7'h57;
    localparam logic [6:0] KEY_F12       = 7'h58;
    localparam logic [6:0] KEY_UP        = 7'h48;
    localparam logic [6:0] KEY_DOWN      = 7'h50;
    localparam logic [6:0] KEY_RIGHT     = 7'h4D;
    localparam logic [6:0] KEY_LEFT      = 7'h4B;
    localparam logic [6:0] KEY_HOME      = 7'h47;
    localparam logic [6:0] KEY_END       = 7'h4F;
    localparam logic [6:0] KEY_DELETE    = 7'h53;

    // Function key targets
    localparam logic [3:0] FKEY_F11_TGT  = 4'd10;
    localparam logic [3:0] FKEY_F12_TGT  = 4'd11;
    localparam logic [3:0] FKEY_LO_COUNT = 4'd5;

    // Terminal bytes
    localparam logic [7:0] ASCII_ESC     = 8'h1B;
    localparam logic [7:0] ASCII_LBRACK  = 8'h5B;
    localparam logic [7:0] ASCII_ETX     = 8'h03;
    localparam logic [7:0] ASCII_TILDE   = 8'h7E;
    localparam logic [7:0] ASCII_THREE   = 8'h33;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;
    localparam logic [7:0] CTRL_OFFSET   = 8'h60;

    // Configuration port
    localparam int         CFG_IDX_W     = 1;
    localparam int         CFG_DATA_W    = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAPHICS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSOLES = 1'd1;
    localparam logic [3:0] CONSOLES_RESET = 4'd1;

    typedef enum logic [2:0] {
        OP_CHAR     = 3'd0,  // single character byte
        OP_INTR     = 3'd1,  // ctrl-C: 0x03 plus interrupt flag
        OP_SWITCH   = 3'd2,  // console switch, no byte
        OP_CSI3     = 3'd3,  // ESC [ arg
        OP_DELETE   = 3'd4,  // ESC [ 3 ~
        OP_FKEY_LO  = 3'd5,  // ESC [ [ arg  (F1..F5)
        OP_FKEY_HI  = 3'd6   // ESC [ d d ~  (F6..F12)
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] arg;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       switch_request;
        logic [3:0] target_console;
        logic       interrupt_request;
        logic       last;
    } res_t;

    function automatic logic [7:0] plain_map(logic [6:0] code);
        logic [7:0] c;
        case (code)
            7'd1:  c = 8'h1B;
            7'd2:  c = "1";
            7'd3:  c = "2";
            7'd4:  c = "3";
            7'd5:  c = "4";
            7'd6:  c = "5";
            7'd7:  c = "6";
            7'd8:  c = "7";
            7'd9:  c = "8";
            7'd10: c = "9";
            7'd11: c = "0";
            7'd12: c = "-";
            7'd13: c = "=";
            7'd14: c = 8'h08;
            7'd15: c = 8'h09;
            7'd16: c = "q";
            7'd17: c = "w";
            7'd18: c = "e";
            7'd19: c = "r";
            7'd20: c = "t";
            7'd21: c = "y";
            7'd22: c = "u";
            7'd23: c = "i";
            7'd24: c = "o";
            7'd25: c = "p";
            7'd26: c = 8'h5B;
            7'd27: c = 8'h5D;
            7'd28: c = 8'h0D;
            7'd30: c = "a";
            7'd31: c = "s";
            7'd32: c = "d";
            7'd33: c = "f";
            7'd34: c = "g";
            7'd35: c = "h";
            7'd36: c = "j";
            7'd37: c = "k";
            7'd38: c = "l";
            7'd39: c = 8'h3B;
            7'd40: c = 8'h27;
            7'd41: c = 8'h60;
            7'd43: c = 8'h5C;
            7'd44: c = "z";
            7'd45: c = "x";
            7'd46: c = "c";
            7'd47: c = "v";
            7'd48: c = "b";
            7'd49: c = "n";
            7'd50: c = "m";
            7'd51: c = 8'h2C;
            7'd52: c = 8'h2E;
            7'd53: c = 8'h2F;
            7'd55: c = 8'h2A;
            7'd57: c = 8'h20;
            7'd74: c = 8'h2D;
            7'd78: c = 8'h2B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] shifted_map(logic [6:0] code);
        logic [7:0] c;
        case (code)
            7'd2:  c = 8'h21;
            7'd3:  c = 8'h40;
            7'd4:  c = 8'h23;
            7'd5:  c = 8'h24;
            7'd6:  c = 8'h25;
            7'd7:  c = 8'h5E;
            7'd8:  c = 8'h26;
            7'd9:  c = 8'h2A;
            7'd10: c = 8'h28;
            7'd11: c = 8'h29;
            7'd12: c = 8'h5F;
            7'd13: c = 8'h2B;
            7'd26: c = 8'h7B;
            7'd27: c = 8'h7D;
            7'd39: c = 8'h3A;
            7'd40: c = 8'h22;
            7'd41: c = 8'h7E;
            7'd43: c = 8'h7C;
            7'd51: c = 8'h3C;
            7'd52: c = 8'h3E;
            7'd53: c = 8'h3F;
            default:
            begin
                c = plain_map(code);
                if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
                begin
                    c = c - CASE_OFFSET;
                end
            end
        endcase
        return c;
    endfunction

    // Two ASCII digits for F6..F12 (index 0..6): 17..21, 23, 24
    function automatic logic [15:0] fkey_digits(logic [2:0] idx);
        logic [15:0] d;
        case (idx)
            3'd0:    d = "17";
            3'd1:    d = "18";
            3'd2:    d = "19";
            3'd3:    d = "20";
            3'd4:    d = "21";
            3'd5:    d = "23";
            3'd6:    d = "24";
            default: d = "00";
        endcase
        return d;
    endfunction

    function automatic logic [2:0] result_len(op_t op);
        logic [2:0] n;
        case (op)
            OP_CSI3:    n = 3'd3;
            OP_DELETE:  n = 3'd4;
            OP_FKEY_LO: n = 3'd4;
            OP_FKEY_HI: n = 3'd5;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic res_t result_item(cmd_t cmd, logic [2:0] pos);
        res_t        r;
        logic [15:0] dig;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        r   = '0;
        dig = fkey_digits(cmd.arg[2:0]);
        b2  = cmd.arg;
        b3  = ASCII_TILDE;
        b4  = ASCII_TILDE;
        r.last = (pos == result_len(cmd.op) - 3'd1);
        case (cmd.op)
            OP_CHAR:
            begin
                r.out_byte = cmd.arg;
                r.has_byte = 1'b1;
            end
            OP_INTR:
            begin
                r.out_byte          = ASCII_ETX;
                r.has_byte          = 1'b1;
                r.interrupt_request = 1'b1;
            end
            OP_SWITCH:
            begin
                r.switch_request = 1'b1;
                r.target_console = cmd.arg[3:0];
            end
            default:
            begin
                case (cmd.op)
                    OP_DELETE:  b2 = ASCII_THREE;
                    OP_FKEY_LO:
                    begin
                        b2 = ASCII_LBRACK;
                        b3 = cmd.arg;
                    end
                    OP_FKEY_HI:
                    begin
                        b2 = dig[15:8];
                        b3 = dig[7:0];
                    end
                    default:    b2 = cmd.arg;
                endcase
                r.has_byte = 1'b1;
                case (pos)
                    3'd0:    r.out_byte = ASCII_ESC;
                    3'd1:    r.out_byte = ASCII_LBRACK;
                    3'd2:    r.out_byte = b2;
                    3'd3:    r.out_byte = b3;
                    default: r.out_byte = b4;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// File: hdl/sctb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctb_front: scancode classifier
// Tracks prefix and modifier state and turns each accepted scancode into at
// most one command for the expansion stage. Holds the configuration registers.
// ----------------------------------------------------------------------------
module sctb_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [7:0]                       scan_byte,
    input  logic                             q_full,
    input  logic                             cfg_write,
    input  logic [sctb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sctb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             cmd_push,
    output sctb_pkg::cmd_t                   cmd
);

    logic       lshift_reg, lshift_next;
    logic       rshift_reg, rshift_next;
    logic       ctrl_reg, ctrl_next;
    logic       alt_reg, alt_next;
    logic       caps_reg, caps_next;
    logic       ext_reg, ext_next;
    logic       gfx_reg, gfx_next;
    logic [3:0] consoles_reg, consoles_next;

    logic       accept;
    logic       rel;
    logic [6:0] code;
    logic       shift;
    logic       fkey_hit;
    logic [3:0] fkey_tgt;
    logic [7:0] plain_c;
    logic [7:0] char_c;
    logic       plain_letter;
    logic       emit;

    assign accept = push && !q_full;
    assign rel    = scan_byte[sctb_pkg::RELEASE_BIT];
    assign code   = scan_byte[6:0];
    assign shift  = lshift_reg || rshift_reg;

    always_comb
    begin
        fkey_hit = 1'b1;
        fkey_tgt = 4'd0;
        if (code inside {[sctb_pkg::KEY_F1:sctb_pkg::KEY_F10]})
        begin
            fkey_tgt = 4'(code - sctb_pkg::KEY_F1);
        end
        else if (code == sctb_pkg::KEY_F11)
        begin
            fkey_tgt = sctb_pkg::FKEY_F11_TGT;
        end
        else if (code == sctb_pkg::KEY_F12)
        begin
            fkey_tgt = sctb_pkg::FKEY_F12_TGT;
        end
        else
        begin
            fkey_hit = 1'b0;
        end
    end

    // Printable character with shift and caps rules applied
    always_comb
    begin
        plain_c      = sctb_pkg::plain_map(code);
        plain_letter = (plain_c >= sctb_pkg::ASCII_LOWER_A) &&
                       (plain_c <= sctb_pkg::ASCII_LOWER_Z);
        char_c       = plain_c;
        if (!plain_letter && shift)
        begin
            char_c = sctb_pkg::shifted_map(code);
        end
        if (char_c >= sctb_pkg::ASCII_LOWER_A && char_c <= sctb_pkg::ASCII_LOWER_Z &&
            (caps_reg != shift))
        begin
            char_c = char_c - sctb_pkg::CASE_OFFSET;
        end
    end

    always_comb
    begin
        lshift_next   = lshift_reg;
        rshift_next   = rshift_reg;
        ctrl_next     = ctrl_reg;
        alt_next      = alt_reg;
        caps_next     = caps_reg;
        ext_next      = ext_reg;
        gfx_next      = gfx_reg;
        consoles_next = consoles_reg;
        emit          = 1'b0;
        cmd.op        = sctb_pkg::OP_CHAR;
        cmd.arg       = 8'd0;

        if (cfg_write)
        begin
            case (cfg_index)
                sctb_pkg::CFG_GRAPHICS: gfx_next      = cfg_data[0];
                sctb_pkg::CFG_CONSOLES: consoles_next = cfg_data;
                default: ;
            endcase
        end

        if (scan_byte == sctb_pkg::SC_PREFIX_EXT)
        begin
            ext_next = 1'b1;
        end
        else
        begin
            ext_next = 1'b0;
            if (ext_reg)
            begin
                if (rel)
                begin
                    if (code == sctb_pkg::KEY_CTRL)     ctrl_next = 1'b0;
                    else if (code == sctb_pkg::KEY_ALT) alt_next  = 1'b0;
                end
                else if (code == sctb_pkg::KEY_CTRL) ctrl_next = 1'b1;
                else if (code == sctb_pkg::KEY_ALT)  alt_next  = 1'b1;
                else if (!gfx_reg)
                begin
                    emit    = 1'b1;
                    cmd.op  = sctb_pkg::OP_CSI3;
                    case (code)
                        sctb_pkg::KEY_UP:     cmd.arg = "A";
                        sctb_pkg::KEY_DOWN:   cmd.arg = "B";
                        sctb_pkg::KEY_RIGHT:  cmd.arg = "C";
                        sctb_pkg::KEY_LEFT:   cmd.arg = "D";
                        sctb_pkg::KEY_HOME:   cmd.arg = "H";
                        sctb_pkg::KEY_END:    cmd.arg = "F";
                        sctb_pkg::KEY_DELETE: cmd.op  = sctb_pkg::OP_DELETE;
                        default:              emit    = 1'b0;
                    endcase
                end
            end
            else if (rel)
            begin
                if (code == sctb_pkg::KEY_LSHIFT)      lshift_next = 1'b0;
                else if (code == sctb_pkg::KEY_RSHIFT) rshift_next = 1'b0;
                else if (code == sctb_pkg::KEY_CTRL)   ctrl_next   = 1'b0;
                else if (code == sctb_pkg::KEY_ALT)    alt_next    = 1'b0;
            end
            else if (code == sctb_pkg::KEY_LSHIFT) lshift_next = 1'b1;
            else if (code == sctb_pkg::KEY_RSHIFT) rshift_next = 1'b1;
            else if (code == sctb_pkg::KEY_CTRL)   ctrl_next   = 1'b1;
            else if (code == sctb_pkg::KEY_ALT)    alt_next    = 1'b1;
            else if (code == sctb_pkg::KEY_CAPS)   caps_next   = !caps_reg;
            else if (ctrl_reg && alt_reg && !gfx_reg && fkey_hit &&
                     (fkey_tgt < consoles_reg))
            begin
                emit    = 1'b1;
                cmd.op  = sctb_pkg::OP_SWITCH;
                cmd.arg = {4'd0, fkey_tgt};
            end
            else if (gfx_reg)
            begin
                emit = 1'b0;
            end
            else if (!ctrl_reg && !alt_reg && fkey_hit)
            begin
                emit = 1'b1;
                if (fkey_tgt < sctb_pkg::FKEY_LO_COUNT)
                begin
                    cmd.op  = sctb_pkg::OP_FKEY_LO;
                    cmd.arg = sctb_pkg::ASCII_UPPER_A + {4'd0, fkey_tgt};
                end
                else
                begin
                    cmd.op  = sctb_pkg::OP_FKEY_HI;
                    cmd.arg = {4'd0, fkey_tgt - sctb_pkg::FKEY_LO_COUNT};
                end
            end
            else if (ctrl_reg && code == sctb_pkg::KEY_C)
            begin
                emit   = 1'b1;
                cmd.op = sctb_pkg::OP_INTR;
            end
            else if (ctrl_reg && plain_letter)
            begin
                emit    = 1'b1;
                cmd.arg = plain_c - sctb_pkg::CTRL_OFFSET;
            end
            else if (char_c != 8'd0)
            begin
                emit    = 1'b1;
                cmd.arg = char_c;
            end
        end
    end

    assign cmd_push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lshift_reg   <= 1'b0;
            rshift_reg   <= 1'b0;
            ctrl_reg     <= 1'b0;
            alt_reg      <= 1'b0;
            caps_reg     <= 1'b0;
            ext_reg      <= 1'b0;
            gfx_reg      <= 1'b0;
            consoles_reg <= sctb_pkg::CONSOLES_RESET;
        end
        else
        begin
            gfx_reg      <= gfx_next;
            consoles_reg <= consoles_next;
            if (accept)
            begin
                lshift_reg <= lshift_next;
                rshift_reg <= rshift_next;
                ctrl_reg   <= ctrl_next;
                alt_reg    <= alt_next;
                caps_reg   <= caps_next;
                ext_reg    <= ext_next;
            end
        end
    end

endmodule

// File: hdl/sctb_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctb_cmdq: command queue
// Small flop-based FIFO between the classifier and the expansion stage.
// ----------------------------------------------------------------------------
module sctb_cmdq
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  sctb_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output sctb_pkg::cmd_t rd_data,
    output logic           nonempty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sctb_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign nonempty = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers meet only when the queue is empty or full
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg == rd_ptr_reg) |-> (count_reg == '0 || count_reg == FULL_CNT))
        else $error("cmdq pointers and count disagree");

endmodule

// File: hdl/sctb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctb_back: command expansion
// Walks one command through its result transactions, one per cycle while the
// output slot is free or popped, into a registered output slot.
// ----------------------------------------------------------------------------
module sctb_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_nonempty,
    input  sctb_pkg::cmd_t q_data,
    output logic           q_take,
    input  logic           pop,
    output logic           out_valid,
    output sctb_pkg::res_t out_res
);

    sctb_pkg::cmd_t cmd_reg, cmd_next;
    logic           cmd_valid_reg, cmd_valid_next;
    logic [2:0]     pos_reg, pos_next;
    sctb_pkg::res_t out_reg, out_next;
    logic           out_valid_reg, out_valid_next;

    sctb_pkg::res_t cur;
    logic           load_out;
    logic           cmd_done;

    always_comb
    begin
        cur      = sctb_pkg::result_item(cmd_reg, pos_reg);
        load_out = cmd_valid_reg && (!out_valid_reg || pop);
        cmd_done = load_out && cur.last;
        q_take   = q_nonempty && (!cmd_valid_reg || cmd_done);

        cmd_next       = q_take ? q_data : cmd_reg;
        cmd_valid_next = q_take ? 1'b1 : (cmd_done ? 1'b0 : cmd_valid_reg);
        if (cmd_done || !cmd_valid_reg)
        begin
            pos_next = 3'd0;
        end
        else if (load_out)
        begin
            pos_next = pos_reg + 3'd1;
        end
        else
        begin
            pos_next = pos_reg;
        end
        out_next       = load_out ? cur : out_reg;
        out_valid_next = load_out ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg |-> (pos_reg < sctb_pkg::result_len(cmd_reg.op)))
        else $error("expansion position past end of sequence");

    a_switch_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.switch_request) |-> (!out_reg.has_byte && out_reg.last))
        else $error("switch request carries a byte or is not last");

    a_intr_etx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.interrupt_request) |->
            (out_reg.has_byte && out_reg.out_byte == sctb_pkg::ASCII_ETX && out_reg.last))
        else $error("interrupt request without ETX byte");

endmodule

// File: hdl/scancode_to_terminal_bytes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_terminal_bytes: set-1 scancode to terminal byte decoder
// Path: command queue, expansion command register, registered output slot.
// Throughput: one scancode per cycle in while full is low; one result per cycle
// out while the slot is free or popped, a command's 1..5 results in sequence.
// Reset: rst_n clears modifier/prefix state, queue and output slot; graphics
// mode resets to 0, console count to 1.
// ----------------------------------------------------------------------------
//
// Structure:
//   sctb_front  - classifies each accepted scancode against the modifier
//                 state and emits at most one command (char, ctrl-C, console
//                 switch or an escape sequence id). Scancodes that only change
//                 state produce no command.
//   sctb_cmdq   - QUEUE_DEPTH-entry command FIFO. Its full flag is the input
//                 full, so scancodes keep flowing while the back end is busy.
//   sctb_back   - expands the head command into its results, one per cycle
//                 while the registered output slot is empty or being popped.
//
// Sustained rate is set by the expansion stage: the output side moves one
// transaction per cycle when pop is held high.
module scancode_to_terminal_bytes
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // scancode input
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       scan_byte,
    // result output
    output logic                             empty,
    input  logic                             pop,
    output logic [7:0]                       out_byte,
    output logic                             has_byte,
    output logic                             switch_request,
    output logic [3:0]                       target_console,
    output logic                             interrupt_request,
    output logic                             last,
    // configuration
    input  logic                             cfg_write,
    input  logic [sctb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sctb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    sctb_pkg::cmd_t front_cmd;
    logic           front_push;
    logic           q_full;
    sctb_pkg::cmd_t q_data;
    logic           q_nonempty;
    logic           q_take;
    logic           out_valid;
    sctb_pkg::res_t out_res;

    // input side stalls only when the command queue is full
    assign full = q_full;

    sctb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .scan_byte (scan_byte),
        .q_full    (q_full),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    sctb_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_data  (front_cmd),
        .full     (q_full),
        .rd_en    (q_take),
        .rd_data  (q_data),
        .nonempty (q_nonempty)
    );

    sctb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (q_data),
        .q_take     (q_take),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_res    (out_res)
    );

    // result transaction fields straight from the output slot
    assign empty             = !out_valid;
    assign out_byte          = out_res.out_byte;
    assign has_byte          = out_res.has_byte;
    assign switch_request    = out_res.switch_request;
    assign target_console    = out_res.target_console;
    assign interrupt_request = out_res.interrupt_request;
    assign last              = out_res.last;

endmodule

// File: bench/scancode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_checker: result prediction and comparison for the scancode decoder
// Watches the scancode, result and register channels. Every accepted scancode
// is decoded against a private copy of the modifier and register state, and
// each result transaction is compared field by field with the oldest one
// predicted.
// ----------------------------------------------------------------------------
module scancode_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic                            full,
    input  logic [7:0]                      scan_byte,
    input  logic                            empty,
    input  logic                            pop,
    input  logic [7:0]                      out_byte,
    input  logic                            has_byte,
    input  logic                            switch_request,
    input  logic [3:0]                      target_console,
    input  logic                            interrupt_request,
    input  logic                            last,
    input  logic                            cfg_write,
    input  logic [sctb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sctb_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              error_count,
    output int                              outstanding,
    output int                              results_checked,
    output int                              switches_seen,
    output int                              interrupts_seen
);

    // Key layers for codes 0..57, first character is code 0.
    // 0x7F marks a key with no glyph.
    localparam int         LAST_MAPPED  = 57;
    localparam logic [7:0] NO_GLYPH     = 8'h7F;
    localparam logic [6:0] KEYPAD_MINUS = 7'h4A;
    localparam logic [6:0] KEYPAD_PLUS  = 7'h4E;

    localparam logic [8*(LAST_MAPPED+1)-1:0] BASE_LAYER = {
        "\177\0331234567890-=\010\011",
        "qwertyuiop[]\015\177",
        "asdfghjkl;'\140\177\\",
        "zxcvbnm,./\177*\177 "
    };
    localparam logic [8*(LAST_MAPPED+1)-1:0] SHIFT_LAYER = {
        "\177\033!@#$%^&*()_+\010\011",
        "QWERTYUIOP{}\015\177",
        "ASDFGHJKL:\"~\177|",
        "ZXCVBNM<>?\177*\177 "
    };

    logic       shift_left;
    logic       shift_right;
    logic       ctrl_active;
    logic       alt_active;
    logic       caps_on;
    logic       prefix_pending;
    logic       graphics_on;
    logic [3:0] console_limit;

    sctb_pkg::res_t pending_results[$];
    int   mismatches;
    int   checked;
    int   switches;
    int   interrupts;

    function automatic logic [7:0] key_glyph(input logic [6:0] code, input logic upper);
        logic [7:0] g;
        g = 8'h00;
        if (code <= LAST_MAPPED)
        begin
            if (upper)
                g = SHIFT_LAYER[8*(LAST_MAPPED-code) +: 8];
            else
                g = BASE_LAYER[8*(LAST_MAPPED-code) +: 8];
        end
        else if (code == KEYPAD_MINUS)
            g = "-";
        else if (code == KEYPAD_PLUS)
            g = "+";
        if (g == NO_GLYPH)
            g = 8'h00;
        return g;
    endfunction

    function automatic logic is_letter(input logic [7:0] g);
        return (g >= "a") && (g <= "z");
    endfunction

    task automatic expect_result(input logic [7:0] b, input logic has, input logic sw,
                                 input logic [3:0] tgt, input logic intr, input logic fin);
        sctb_pkg::res_t r;
        r.out_byte          = b;
        r.has_byte          = has;
        r.switch_request    = sw;
        r.target_console    = tgt;
        r.interrupt_request = intr;
        r.last              = fin;
        pending_results.push_back(r);
    endtask

    // seq is right aligned: the first byte sits highest
    task automatic expect_sequence(input logic [39:0] seq, input int len);
        for (int i = 0; i < len; i++)
            expect_result(seq[8*(len-1-i) +: 8], 1'b1, 1'b0, 4'd0, 1'b0, i == len - 1);
    endtask

    task automatic decode_scancode(input logic [7:0] sc);
        logic [6:0] code;
        logic       released;
        logic       after_prefix;
        logic       shifted;
        logic [7:0] g;
        int         target;
        int         fnum;

        if (sc == sctb_pkg::SC_PREFIX_EXT)
        begin
            prefix_pending = 1'b1;
            return;
        end
        after_prefix   = prefix_pending;
        prefix_pending = 1'b0;
        released       = sc[sctb_pkg::RELEASE_BIT];
        code           = sc[6:0];

        // extended keys: right ctrl/alt and the navigation block only
        if (after_prefix)
        begin
            if (released)
            begin
                if (code == sctb_pkg::KEY_CTRL)
                    ctrl_active = 1'b0;
                else if (code == sctb_pkg::KEY_ALT)
                    alt_active = 1'b0;
                return;
            end
            if (code == sctb_pkg::KEY_CTRL)
            begin
                ctrl_active = 1'b1;
                return;
            end
            if (code == sctb_pkg::KEY_ALT)
            begin
                alt_active = 1'b1;
                return;
            end
            if (graphics_on)
                return;
            case (code)
                sctb_pkg::KEY_UP:
                    expect_sequence({sctb_pkg::ASCII_ESC, sctb_pkg::ASCII_LBRACK, "A"}, 3);
                sctb_pkg::KEY_DOWN:
                    expect_sequence({sctb_pkg::ASCII_ESC, sctb_pkg::ASCII_LBRACK, "B"}, 3);
                sctb_pkg::KEY_RIGHT:
                    expect_sequence({sctb_pkg::ASCII_ESC, sctb_pkg::ASCII_LBRACK, "C"}, 3);
                sctb_pkg::KEY_LEFT:
                    expect_sequence({sctb_pkg::ASCII_ESC, sctb_pkg::ASCII_LBRACK, "D"}, 3);
                sctb_pkg::KEY_HOME:
                    expect_sequence({sctb_pkg::ASCII_ESC, sctb_pkg::ASCII_LBRACK, "H"}, 3);
                sctb_pkg::KEY_END:
                    expect_sequence({sctb_pkg::ASCII_ESC, sctb_pkg::ASCII_LBRACK, "F"}, 3);
                sctb_pkg::KEY_DELETE:
                    expect_sequence({sctb_pkg::ASCII_ESC, sctb_pkg::ASCII_LBRACK, "3",
                                     sctb_pkg::ASCII_TILDE}, 4);
                default:    ;
            endcase
            return;
        end

        if (released)
        begin
            if (code == sctb_pkg::KEY_LSHIFT)
                shift_left = 1'b0;
            else if (code == sctb_pkg::KEY_RSHIFT)
                shift_right = 1'b0;
            else if (code == sctb_pkg::KEY_CTRL)
                ctrl_active = 1'b0;
            else if (code == sctb_pkg::KEY_ALT)
                alt_active = 1'b0;
            return;
        end

        case (code)
            sctb_pkg::KEY_LSHIFT: shift_left  = 1'b1;
            sctb_pkg::KEY_RSHIFT: shift_right = 1'b1;
            sctb_pkg::KEY_CTRL:   ctrl_active = 1'b1;
            sctb_pkg::KEY_ALT:    alt_active  = 1'b1;
            sctb_pkg::KEY_CAPS:   caps_on     = !caps_on;
            default:    ;
        endcase
        if (code inside {sctb_pkg::KEY_LSHIFT, sctb_pkg::KEY_RSHIFT, sctb_pkg::KEY_CTRL,
                         sctb_pkg::KEY_ALT, sctb_pkg::KEY_CAPS})
            return;

        // ctrl-alt-Fn, only for consoles that exist
        if (ctrl_active && alt_active && !graphics_on)
        begin
            target = -1;
            if (code >= sctb_pkg::KEY_F1 && code <= sctb_pkg::KEY_F10)
                target = code - sctb_pkg::KEY_F1;
            else if (code == sctb_pkg::KEY_F11)
                target = sctb_pkg::FKEY_F11_TGT;
            else if (code == sctb_pkg::KEY_F12)
                target = sctb_pkg::FKEY_F12_TGT;
            if (target >= 0 && target < int'(console_limit))
            begin
                expect_result(8'h00, 1'b0, 1'b1, 4'(target), 1'b0, 1'b1);
                return;
            end
        end

        if (graphics_on)
            return;

        if (!ctrl_active && !alt_active)
        begin
            if (code >= sctb_pkg::KEY_F1 && code <= sctb_pkg::KEY_F5)
            begin
                expect_sequence({sctb_pkg::ASCII_ESC, sctb_pkg::ASCII_LBRACK,
                                 sctb_pkg::ASCII_LBRACK,
                                 8'(sctb_pkg::ASCII_UPPER_A + (code - sctb_pkg::KEY_F1))}, 4);
                return;
            end
            if ((code >= sctb_pkg::KEY_F6 && code <= sctb_pkg::KEY_F10) ||
                code == sctb_pkg::KEY_F11 || code == sctb_pkg::KEY_F12)
            begin
                // F6..F10 are 17..21, F11 and F12 skip 22
                if (code == sctb_pkg::KEY_F11)
                    fnum = 23;
                else if (code == sctb_pkg::KEY_F12)
                    fnum = 24;
                else
                    fnum = 17 + (code - sctb_pkg::KEY_F6);
                expect_sequence({sctb_pkg::ASCII_ESC, sctb_pkg::ASCII_LBRACK,
                                 8'("0" + fnum / 10), 8'("0" + fnum % 10),
                                 sctb_pkg::ASCII_TILDE}, 5);
                return;
            end
        end

        if (ctrl_active && code == sctb_pkg::KEY_C)
        begin
            expect_result(sctb_pkg::ASCII_ETX, 1'b1, 1'b0, 4'd0, 1'b1, 1'b1);
            return;
        end

        if (ctrl_active)
        begin
            g = key_glyph(code, 1'b0);
            if (is_letter(g))
            begin
                expect_result(g - sctb_pkg::ASCII_LOWER_A + 8'd1, 1'b1, 1'b0, 4'd0, 1'b0,
                              1'b1);
                return;
            end
        end

        shifted = shift_left || shift_right;
        g = key_glyph(code, 1'b0);
        if (!is_letter(g) && shifted)
            g = key_glyph(code, 1'b1);
        if (is_letter(g) && (caps_on != shifted))
            g = g - sctb_pkg::CASE_OFFSET;
        if (g != 8'h00)
            expect_result(g, 1'b1, 1'b0, 4'd0, 1'b0, 1'b1);
    endtask

    // four-state compare so that an unknown field counts as a mismatch
    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        sctb_pkg::res_t want;
        if (pending_results.size() == 0)
        begin
            $error("result with nothing predicted: out_byte 0x%0h switch %0b", out_byte,
                   switch_request);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            check_field("out_byte", want.out_byte, out_byte);
            check_field("has_byte", 8'(want.has_byte), 8'(has_byte));
            check_field("switch_request", 8'(want.switch_request), 8'(switch_request));
            check_field("target_console", 8'(want.target_console), 8'(target_console));
            check_field("interrupt_request", 8'(want.interrupt_request),
                        8'(interrupt_request));
            check_field("last", 8'(want.last), 8'(last));
        end
        checked++;
        if (switch_request === 1'b1)
            switches++;
        if (interrupt_request === 1'b1)
            interrupts++;
    endtask

    initial
    begin
        mismatches = 0;
        checked    = 0;
        switches   = 0;
        interrupts = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_left     = 1'b0;
            shift_right    = 1'b0;
            ctrl_active    = 1'b0;
            alt_active     = 1'b0;
            caps_on        = 1'b0;
            prefix_pending = 1'b0;
            graphics_on    = 1'b0;
            console_limit  = sctb_pkg::CONSOLES_RESET;
            pending_results.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == sctb_pkg::CFG_GRAPHICS)
                    graphics_on = cfg_data[0];
                else if (cfg_index == sctb_pkg::CFG_CONSOLES)
                    console_limit = cfg_data;
            end
            if (push && !full)
                decode_scancode(scan_byte);
            if (pop && !empty)
                check_result();
        end
        // published with NBA so the stimulus side reads a stable value
        error_count     <= mismatches;
        outstanding     <= pending_results.size();
        results_checked <= checked;
        switches_seen   <= switches;
        interrupts_seen <= interrupts;
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the scancode decoder
// Drives scancode transactions in bursts, stalls the result side on its own
// pattern, steps the registers through several settings between phases and
// leaves prediction and checking to scancode_checker.
// ----------------------------------------------------------------------------
module testbench;

    // A few plain keys used by the opening directed sequence
    localparam logic [6:0] KEY_A  = 7'h1E;
    localparam logic [6:0] KEY_1  = 7'h02;
    localparam logic [6:0] KEY_F2 = 7'h3C;

    localparam int    STROKES_PER_PHASE = 27;   // six phases, ~390 random scancodes
    localparam int    PHASES            = 6;
    localparam int    DRAIN_CYCLES      = 16;   // covers pipe + command queue
    localparam int    HALF_PERIOD       = 10;
    localparam longint LIMIT_NS         = 8_000_000;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            push      = 1'b0;
    logic [7:0]                      scan_byte = 8'h00;
    logic                            pop       = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [sctb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sctb_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       switch_request;
    logic [3:0] target_console;
    logic       interrupt_request;
    logic       last;

    int error_count;
    int outstanding;
    int results_checked;
    int switches_seen;
    int interrupts_seen;

    // sender burst bookkeeping
    int burst_left       = 0;
    int scancodes_sent   = 0;
    int settings_applied = 0;

    // result-side stall pattern
    logic [11:0] pop_pattern = '1;
    int unsigned pop_tick    = 0;

    always #(HALF_PERIOD) clk = ~clk;

    scancode_to_terminal_bytes i_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .scan_byte         (scan_byte),
        .empty             (empty),
        .pop               (pop),
        .out_byte          (out_byte),
        .has_byte          (has_byte),
        .switch_request    (switch_request),
        .target_console    (target_console),
        .interrupt_request (interrupt_request),
        .last              (last),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    scancode_checker i_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .scan_byte         (scan_byte),
        .empty             (empty),
        .pop               (pop),
        .out_byte          (out_byte),
        .has_byte          (has_byte),
        .switch_request    (switch_request),
        .target_console    (target_console),
        .interrupt_request (interrupt_request),
        .last              (last),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .error_count       (error_count),
        .outstanding       (outstanding),
        .results_checked   (results_checked),
        .switches_seen     (switches_seen),
        .interrupts_seen   (interrupts_seen)
    );

    // Result side: pop steps through a 12-bit pattern; pop_tick decides when the
    // pattern is reloaded. Some reloads are all ones (no stalls), some are sparse
    // so that long stalls land on every position of a multi-byte sequence.
    always @(negedge clk)
    begin
        if (pop_tick % 48 == 0)
        begin
            case ($urandom_range(0, 3))
                0:       pop_pattern = '1;
                1:       pop_pattern = 12'($urandom) | 12'h001;
                2:       pop_pattern = 12'h801;
                default: pop_pattern = 12'($urandom) | 12'h555;
            endcase
        end
        pop <= pop_pattern[pop_tick % 12];
        pop_tick++;
    end

    // One scancode transaction. The sender runs in bursts: when a burst is
    // used up, push drops for a random gap (sometimes none) before the next
    // one starts. Push stays high between items of a burst.
    task automatic send_scancode(input logic [7:0] sc);
        int  gap;
        logic taken;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        push      <= 1'b1;
        scan_byte <= sc;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !full;
        end
        burst_left--;
        scancodes_sent++;
    endtask

    // Press / release, optionally behind the extended prefix
    task automatic key_down(input logic [6:0] code, input logic ext);
        if (ext)
            send_scancode(sctb_pkg::SC_PREFIX_EXT);
        send_scancode({1'b0, code});
    endtask

    task automatic key_up(input logic [6:0] code, input logic ext);
        if (ext)
            send_scancode(sctb_pkg::SC_PREFIX_EXT);
        send_scancode({1'b1, code});
    endtask

    // Stop sending and let every predicted result drain. The extra cycles
    // cover scancodes that make no result but may still be in the pipe.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both registers in one go, only once the block is idle. Spare bits of
    // the graphics word are random; only bit 0 counts.
    task automatic apply_settings(input logic graphics, input logic [3:0] consoles);
        logic [sctb_pkg::CFG_DATA_W-1:0] word;
        settle();
        word    = sctb_pkg::CFG_DATA_W'($urandom);
        word[0] = graphics;
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sctb_pkg::CFG_GRAPHICS;
        cfg_data  <= word;
        @(negedge clk);
        cfg_index <= sctb_pkg::CFG_CONSOLES;
        cfg_data  <= consoles;
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [6:0] fkey_code(input int idx);
        if (idx < 10)
            return sctb_pkg::KEY_F1 + 7'(idx);
        return (idx == 10) ? sctb_pkg::KEY_F11 : sctb_pkg::KEY_F12;
    endfunction

    // One random keyboard action. Mostly well-formed press/release
    // sequences with random keys, plus modifier changes and raw noise.
    task automatic random_keystroke();
        int         pick;
        logic [6:0] code;
        logic       ext_ctrl;
        logic       ext_alt;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            // printable area, now and then the keypad or any code at all
            case ($urandom_range(0, 9))
                0:       code = 7'h4A;
                1:       code = 7'h4E;
                2:       code = 7'($urandom);
                default: code = 7'($urandom_range(1, 57));
            endcase
            key_down(code, 1'b0);
            if ($urandom_range(0, 1))
                key_up(code, 1'b0);
        end
        else if (pick < 42)
        begin
            // modifier change; extended shift and caps are to be ignored
            case ($urandom_range(0, 7))
                0:       code = sctb_pkg::KEY_LSHIFT;
                1:       code = sctb_pkg::KEY_RSHIFT;
                2:       code = sctb_pkg::KEY_CTRL;
                3:       code = sctb_pkg::KEY_ALT;
                4:       code = sctb_pkg::KEY_CAPS;
                default: code = sctb_pkg::KEY_LSHIFT;
            endcase
            ext_ctrl = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
                key_down(code, ext_ctrl);
            else
                key_up(code, ext_ctrl);
        end
        else if (pick < 55)
        begin
            code = fkey_code($urandom_range(0, 11));
            key_down(code, 1'b0);
            if ($urandom_range(0, 1))
                key_up(code, 1'b0);
        end
        else if (pick < 70)
        begin
            // navigation block, sometimes an unused extended code
            case ($urandom_range(0, 7))
                0:       code = sctb_pkg::KEY_UP;
                1:       code = sctb_pkg::KEY_DOWN;
                2:       code = sctb_pkg::KEY_RIGHT;
                3:       code = sctb_pkg::KEY_LEFT;
                4:       code = sctb_pkg::KEY_HOME;
                5:       code = sctb_pkg::KEY_END;
                6:       code = sctb_pkg::KEY_DELETE;
                default: code = 7'($urandom);
            endcase
            key_down(code, 1'b1);
            if ($urandom_range(0, 2) == 0)
                key_up(code, 1'b1);
        end
        else if (pick < 80)
        begin
            // console switch chord, left or right modifiers
            ext_ctrl = 1'($urandom_range(0, 1));
            ext_alt  = 1'($urandom_range(0, 1));
            code     = fkey_code($urandom_range(0, 11));
            key_down(sctb_pkg::KEY_CTRL, ext_ctrl);
            key_down(sctb_pkg::KEY_ALT, ext_alt);
            key_down(code, 1'b0);
            key_up(code, 1'b0);
            key_up(sctb_pkg::KEY_ALT, ext_alt);
            key_up(sctb_pkg::KEY_CTRL, ext_ctrl);
        end
        else if (pick < 88)
        begin
            // ctrl chord, ctrl-C half of the time
            code = $urandom_range(0, 1) ? sctb_pkg::KEY_C : 7'($urandom_range(1, 57));
            key_down(sctb_pkg::KEY_CTRL, 1'($urandom_range(0, 1)));
            key_down(code, 1'b0);
            key_up(sctb_pkg::KEY_CTRL, 1'b0);
        end
        else
        begin
            send_scancode(8'($urandom));
        end
    endtask

    // Watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("FAIL scancode_to_terminal_bytes");
        $finish;
    end

    initial
    begin
        logic       phase_graphics [PHASES];
        logic [3:0] phase_consoles [PHASES];

        // settings walked by the random phases: full range, zero consoles, graphics
        // on with switch chords, more than twelve, one random, and graphics with none
        phase_graphics = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        phase_consoles = '{4'd12, 4'd0, 4'd12, 4'd15, 4'($urandom_range(1, 11)), 4'd0};

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening at reset settings (graphics off, one console)
        key_down(KEY_A, 1'b0);                  // plain letter
        key_down(sctb_pkg::KEY_LSHIFT, 1'b0);
        key_down(KEY_A, 1'b0);                  // shifted letter
        key_down(KEY_1, 1'b0);                  // shifted symbol
        key_up(sctb_pkg::KEY_LSHIFT, 1'b0);
        key_down(sctb_pkg::KEY_CAPS, 1'b0);
        key_down(KEY_A, 1'b0);                  // caps alone: upper case
        key_down(sctb_pkg::KEY_RSHIFT, 1'b0);
        key_down(KEY_A, 1'b0);                  // caps and shift cancel
        key_up(sctb_pkg::KEY_RSHIFT, 1'b0);
        key_down(sctb_pkg::KEY_CAPS, 1'b0);
        key_down(sctb_pkg::KEY_CTRL, 1'b0);
        key_down(sctb_pkg::KEY_C, 1'b0);        // interrupt
        key_down(KEY_A, 1'b0);                  // control code
        key_down(sctb_pkg::KEY_ALT, 1'b1);
        key_down(sctb_pkg::KEY_F1, 1'b0);       // switch to console 0
        key_down(KEY_F2, 1'b0);                 // out of range: nothing with ctrl held
        key_up(sctb_pkg::KEY_ALT, 1'b1);
        key_up(sctb_pkg::KEY_CTRL, 1'b0);
        key_down(sctb_pkg::KEY_DELETE, 1'b1);
        key_down(sctb_pkg::KEY_LSHIFT, 1'b1);   // extended shift is ignored
        key_down(KEY_A, 1'b0);
        key_down(sctb_pkg::KEY_F11, 1'b0);
        send_scancode(8'hFF);
        send_scancode(8'h00);

        // Random phases, one register setting each
        for (int p = 0; p < PHASES; p++)
        begin
            apply_settings(phase_graphics[p], phase_consoles[p]);
            for (int k = 0; k < STROKES_PER_PHASE; k++)
                random_keystroke();
        end

        settle();

        $display("Sent %0d scancodes under %0d register settings after reset defaults.",
                 scancodes_sent, settings_applied);
        $display("Checked %0d result transactions: %0d console switches, %0d interrupts.",
                 results_checked, switches_seen, interrupts_seen);
        if (error_count == 0 && outstanding == 0)
            $display("PASS scancode_to_terminal_bytes");
        else
            $display("FAIL scancode_to_terminal_bytes");
        $finish;
    end

endmodule

// File: sim.f
hdl/sctb_pkg.sv
hdl/sctb_front.sv
hdl/sctb_cmdq.sv
hdl/sctb_back.sv
hdl/scancode_to_terminal_bytes.sv
bench/scancode_checker.sv
bench/testbench.sv
